// ===== hw/rtl/pcpd_pkg.sv =====
// ============================================================================
// pcpd_pkg: shared types and helpers for the PID controller unit
// Register indexes, loop modes, datapath widths and the magnitude clamp used by
// the positional and incremental control laws.
// ============================================================================
package pcpd_pkg;

    // Field widths of the streams and the configuration port.
    localparam int SAMPLE_W = 32;           // setpoint, feedback, drive
    localparam int GAIN_W   = 31;           // gains, limits, dead zone, ceiling
    localparam int IN_W     = 2 * SAMPLE_W; // packed input transaction
    localparam int OUT_W    = SAMPLE_W;     // packed result transaction
    localparam int ERR_W    = SAMPLE_W + 1; // raw error before range check
    localparam int DIFF_W   = SAMPLE_W + 2; // first and second differences
    localparam int PROD_W   = GAIN_W + 1 + DIFF_W;
    localparam int FRAC_W   = 16;           // Q16.16 fraction bits
    localparam int MUL_W    = PROD_W - FRAC_W;
    localparam int SUM_W    = 52;           // wide accumulation, never wraps

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_I         = 3'd1,
        CFG_GAIN_D         = 3'd2,
        CFG_INTEGRAL_CLAMP = 3'd3,
        CFG_OUTPUT_CLAMP   = 3'd4,
        CFG_DEAD_ZONE      = 3'd5,
        CFG_ERROR_CEILING  = 3'd6,
        CFG_LOOP_MODE      = 3'd7
    } cfg_index_t;

    // Control law selection.
    typedef enum logic {
        MODE_POSITIONAL  = 1'b0,
        MODE_INCREMENTAL = 1'b1
    } loop_mode_t;

    // Reset value of the limit registers.
    localparam logic [GAIN_W-1:0] LIMIT_MAX = {GAIN_W{1'b1}};

    // Limit a wide signed value to plus or minus an unsigned magnitude.
    function automatic logic signed [SAMPLE_W-1:0] clamp_abs(
        input logic signed [SUM_W-1:0] v,
        input logic [GAIN_W-1:0]       lim
    );
        logic signed [SUM_W-1:0] pos_lim;
        logic signed [SUM_W-1:0] neg_lim;
        logic signed [SUM_W-1:0] res;
        pos_lim = $signed({{(SUM_W-GAIN_W){1'b0}}, lim});
        neg_lim = -pos_lim;
        if (v > pos_lim) begin
            res = pos_lim;
        end else if (v < neg_lim) begin
            res = neg_lim;
        end else begin
            res = v;
        end
        return res[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/pid_controller_pos_delta_unit.sv =====
// ============================================================================
// pid_controller_pos_delta_unit: positional / incremental PID controller
// Signed Q16.16 PID law with dead zone, error ceiling and magnitude clamps.
// ============================================================================
//
// Usage:
//   Input transactions carry setpoint and feedback on s_tdata. Each one
//   produces exactly one result transaction: drive on m_tdata and the
//   skipped flag on m_tuser. A skipped sample reports drive zero and leaves
//   the controller history untouched.
//   An accepted sample passes one input register, then the error, the
//   three gain multipliers, the integrator and the clamps in a single pass
//   into the result register. A new sample is accepted every cycle while
//   the receiver takes results; the sample rate is bounded by that single
//   pass, since each sample needs the history left by the one before.
//   When the receiver stalls, the result register holds its transaction and
//   the input register takes one more sample; s_tready then drops until the
//   result is taken.
//   Reset (aresetn low, synchronous) empties both registers, clears the error
//   history, integrator and last incremental output, and loads the register
//   defaults. Configuration writes are applied at once and are meant to be
//   issued only while no sample is in flight.
//
module pid_controller_pos_delta_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_addr,
    input  logic [pcpd_pkg::GAIN_W-1:0]    cfg_wdata,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pcpd_pkg::IN_W-1:0]      s_tdata,   // [31:0] setpoint, [63:32] feedback
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pcpd_pkg::OUT_W-1:0]     m_tdata,   // [31:0] drive
    output logic [0:0]                     m_tuser    // [0] skipped
);

    localparam int SW = pcpd_pkg::SAMPLE_W;
    localparam int GW = pcpd_pkg::GAIN_W;

    // Configuration registers.
    logic [GW-1:0]        gain_p_reg, gain_i_reg, gain_d_reg;
    logic [GW-1:0]        integral_clamp_reg, output_clamp_reg;
    logic [GW-1:0]        dead_zone_reg, error_ceiling_reg;
    pcpd_pkg::loop_mode_t loop_mode_reg;

    // Controller history.
    logic signed [SW-1:0] prev_error_reg, prev_prev_error_reg;
    logic signed [SW-1:0] integrator_reg, prev_incr_output_reg;

    // Pipeline registers.
    logic                         in_valid_reg;
    logic [pcpd_pkg::IN_W-1:0]    in_data_reg;
    logic                         out_valid_reg;
    logic signed [SW-1:0]         out_drive_reg;
    logic                         out_skipped_reg;

    logic advance;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            integral_clamp_reg <= pcpd_pkg::LIMIT_MAX;
            output_clamp_reg   <= pcpd_pkg::LIMIT_MAX;
            dead_zone_reg      <= '0;
            error_ceiling_reg  <= pcpd_pkg::LIMIT_MAX;
            loop_mode_reg      <= pcpd_pkg::MODE_POSITIONAL;
        end else if (cfg_we) begin
            unique case (pcpd_pkg::cfg_index_t'(cfg_addr))
                pcpd_pkg::CFG_GAIN_P:         gain_p_reg         <= cfg_wdata;
                pcpd_pkg::CFG_GAIN_I:         gain_i_reg         <= cfg_wdata;
                pcpd_pkg::CFG_GAIN_D:         gain_d_reg         <= cfg_wdata;
                pcpd_pkg::CFG_INTEGRAL_CLAMP: integral_clamp_reg <= cfg_wdata;
                pcpd_pkg::CFG_OUTPUT_CLAMP:   output_clamp_reg   <= cfg_wdata;
                pcpd_pkg::CFG_DEAD_ZONE:      dead_zone_reg      <= cfg_wdata;
                pcpd_pkg::CFG_ERROR_CEILING:  error_ceiling_reg  <= cfg_wdata;
                pcpd_pkg::CFG_LOOP_MODE:
                    loop_mode_reg <= pcpd_pkg::loop_mode_t'(cfg_wdata[0]);
                default: ;
            endcase
        end
    end

    // Flow control: the sample in the input register moves on whenever the
    // result register is empty or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    // Error and its range check.
    logic signed [SW-1:0]                  setpoint, feedback;
    logic signed [pcpd_pkg::ERR_W-1:0]     err;
    logic [pcpd_pkg::ERR_W-1:0]            err_mag;
    logic                                  skip;
    logic signed [SW-1:0]                  err32;

    assign setpoint = $signed(in_data_reg[SW-1:0]);
    assign feedback = $signed(in_data_reg[2*SW-1:SW]);
    assign err      = pcpd_pkg::ERR_W'(setpoint) - pcpd_pkg::ERR_W'(feedback);
    assign err_mag  = err[pcpd_pkg::ERR_W-1] ? $unsigned(-err) : $unsigned(err);
    assign skip     = (err_mag > {2'b00, error_ceiling_reg})
                   || (err_mag < {2'b00, dead_zone_reg});
    // A processed error never exceeds the ceiling, so it fits the sample width.
    assign err32    = err[SW-1:0];

    // First and second differences of the error.
    logic signed [pcpd_pkg::DIFF_W-1:0] err_x, prev_x, prev_prev_x, diff1, diff2;

    assign err_x       = pcpd_pkg::DIFF_W'(err32);
    assign prev_x      = pcpd_pkg::DIFF_W'(prev_error_reg);
    assign prev_prev_x = pcpd_pkg::DIFF_W'(prev_prev_error_reg);
    assign diff1       = err_x - prev_x;
    assign diff2       = diff1 - prev_x + prev_prev_x;

    // Multiplier operands follow the control law.
    logic                               incr;
    logic signed [pcpd_pkg::DIFF_W-1:0] op_p, op_d;

    assign incr = (loop_mode_reg == pcpd_pkg::MODE_INCREMENTAL);
    assign op_p = incr ? diff1 : err_x;
    assign op_d = incr ? diff2 : diff1;

    // Gain products, floored to Q16.16.
    logic signed [pcpd_pkg::PROD_W-1:0] prod_p, prod_i, prod_d;
    logic signed [pcpd_pkg::MUL_W-1:0]  term_p, term_i_raw, term_d;

    assign prod_p     = $signed({1'b0, gain_p_reg}) * op_p;
    assign prod_i     = $signed({1'b0, gain_i_reg}) * err_x;
    assign prod_d     = $signed({1'b0, gain_d_reg}) * op_d;
    assign term_p     = prod_p[pcpd_pkg::PROD_W-1:pcpd_pkg::FRAC_W];
    assign term_i_raw = prod_i[pcpd_pkg::PROD_W-1:pcpd_pkg::FRAC_W];
    assign term_d     = prod_d[pcpd_pkg::PROD_W-1:pcpd_pkg::FRAC_W];

    // Integral term: the saturating integrator in positional mode, the
    // clamped product alone in incremental mode.
    logic signed [pcpd_pkg::SUM_W-1:0] integ_pre, total, base;
    logic signed [SW-1:0]              term_i, drive_val;

    assign integ_pre = incr ? pcpd_pkg::SUM_W'(term_i_raw)
                            : pcpd_pkg::SUM_W'(integrator_reg)
                              + pcpd_pkg::SUM_W'(term_i_raw);
    assign term_i    = pcpd_pkg::clamp_abs(integ_pre, integral_clamp_reg);

    // Output sum and clamp.
    assign base      = incr ? pcpd_pkg::SUM_W'(prev_incr_output_reg) : '0;
    assign total     = base + pcpd_pkg::SUM_W'(term_p) + pcpd_pkg::SUM_W'(term_i)
                     + pcpd_pkg::SUM_W'(term_d);
    assign drive_val = pcpd_pkg::clamp_abs(total, output_clamp_reg);

    // Controller history updates on every processed sample.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_error_reg       <= '0;
            prev_prev_error_reg  <= '0;
            integrator_reg       <= '0;
            prev_incr_output_reg <= '0;
        end else if (advance && !skip) begin
            prev_prev_error_reg <= prev_error_reg;
            prev_error_reg      <= err32;
            if (incr) begin
                prev_incr_output_reg <= drive_val;
            end else begin
                integrator_reg <= term_i;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_drive_reg   <= skip ? '0 : drive_val;
            out_skipped_reg <= skip;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_drive_reg;
    assign m_tuser[0] = out_skipped_reg;

endmodule

// ===== hw/rtl/pcpd_checker.sv =====
// ============================================================================
// pcpd_checker: port-level assertions for the PID controller unit
// Checks result stalls, skipped results, reset and input backpressure.
// ============================================================================
module pcpd_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [pcpd_pkg::OUT_W-1:0] m_tdata,
    input logic [0:0]                 m_tuser
);

    // A stalled result transaction holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result transaction changed while stalled");

    // A skipped sample always reports zero drive.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("skipped result with nonzero drive");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Input backpressure only comes from a stalled, full result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a stalled result");

    // Once the input stalls and the result is taken, the input is free again.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && s_tvalid ##1 m_tready |-> s_tready)
        else $error("input still stalled after the result was taken");

endmodule

bind pid_controller_pos_delta_unit pcpd_checker u_pcpd_checker (.*);

// ===== test/tb_pid_controller_pos_delta_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_pid_controller_pos_delta_unit: self-checking bench for the PID unit
// A directed table walks the range limits, dead zone and ceiling edges, the
// clamps and both control laws. Randomized phases with fresh register
// settings follow. A bit-exact drive forecast is compared with every result
// transaction, with random idle cycles on both streams.
// ============================================================================
module tb_pid_controller_pos_delta_unit;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 210;

    localparam int GAIN_W = pcpd_pkg::GAIN_W;
    localparam int IN_W   = pcpd_pkg::IN_W;
    localparam int OUT_W  = pcpd_pkg::OUT_W;
    localparam logic [GAIN_W-1:0] LIMIT_MAX = pcpd_pkg::LIMIT_MAX;

    // Wide signed type for products and sums, so that nothing wraps.
    typedef logic signed [79:0] wide_t;

    typedef struct packed {
        logic [31:0] drive;
        logic        skipped;
    } outcome_t;

    // One row of the directed table: a register write or a sample.
    typedef struct packed {
        bit                   is_write;
        pcpd_pkg::cfg_index_t reg_idx;
        logic [31:0]          a;         // register value or setpoint
        logic [31:0]          b;         // feedback
        bit                   known;
        outcome_t             result;
    } plan_row_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [2:0]          cfg_addr  = '0;
    logic [GAIN_W-1:0]   cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic [0:0]          m_tuser;

    pid_controller_pos_delta_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [31:0] setpoint, [63:32] feedback
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [31:0] drive
        .m_tuser   (m_tuser)    // [0] skipped
    );

    always #6 aclk = ~aclk;

    // Mirror of the register file.
    logic [GAIN_W-1:0]    kp, ki, kd, integ_lim, out_lim, dead_band, err_ceiling;
    pcpd_pkg::loop_mode_t law;

    // Controller history as the forecast sees it.
    wide_t err_z1, err_z2, integ_acc, incr_hold;

    outcome_t  drive_forecast[$];
    plan_row_t plan[$];
    int        mismatches  = 0;
    int        idle_cycles = 0;
    bit        steady      = 1'b0;   // no idling on either side while set

    function automatic wide_t widen(input logic [GAIN_W-1:0] v);
        return $signed({{(80-GAIN_W){1'b0}}, v});
    endfunction

    // Q16.16 product, shifted down with rounding toward minus infinity.
    function automatic wide_t q16_mul(input logic [GAIN_W-1:0] gain, input wide_t x);
        wide_t g;
        g = widen(gain);
        return (g * x) >>> 16;
    endfunction

    function automatic wide_t limit_mag(input wide_t v, input logic [GAIN_W-1:0] lim);
        wide_t l;
        l = widen(lim);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    // Forecast the result of one sample and advance the controller history.
    function automatic outcome_t predict_drive(input logic [31:0] sp, input logic [31:0] fb);
        wide_t    a, b, e, mag, pt, it, dt, y;
        outcome_t r;
        a = wide_t'($signed(sp));
        b = wide_t'($signed(fb));
        e = a - b;
        mag = (e < 0) ? -e : e;
        r.drive   = '0;
        r.skipped = 1'b1;
        // Out of range or inside the dead zone: no state changes.
        if (mag > widen(err_ceiling) || mag < widen(dead_band)) return r;
        if (law == pcpd_pkg::MODE_POSITIONAL) begin
            pt = q16_mul(kp, e);
            dt = q16_mul(kd, e - err_z1);
            integ_acc = limit_mag(integ_acc + q16_mul(ki, e), integ_lim);
            y = limit_mag(pt + integ_acc + dt, out_lim);
        end else begin
            pt = q16_mul(kp, e - err_z1);
            it = limit_mag(q16_mul(ki, e), integ_lim);
            dt = q16_mul(kd, e - err_z1 - err_z1 + err_z2);
            y = limit_mag(incr_hold + pt + it + dt, out_lim);
            incr_hold = y;
        end
        err_z2 = err_z1;
        err_z1 = e;
        r.drive   = y[31:0];
        r.skipped = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Write one register and update the mirror; the design must be idle.
    task automatic write_reg(input pcpd_pkg::cfg_index_t idx,
                             input logic [GAIN_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            pcpd_pkg::CFG_GAIN_P:         kp = val;
            pcpd_pkg::CFG_GAIN_I:         ki = val;
            pcpd_pkg::CFG_GAIN_D:         kd = val;
            pcpd_pkg::CFG_INTEGRAL_CLAMP: integ_lim = val;
            pcpd_pkg::CFG_OUTPUT_CLAMP:   out_lim = val;
            pcpd_pkg::CFG_DEAD_ZONE:      dead_band = val;
            pcpd_pkg::CFG_ERROR_CEILING:  err_ceiling = val;
            default:                      law = pcpd_pkg::loop_mode_t'(val[0]);
        endcase
        @(posedge aclk);
    endtask

    // Offer one sample; the forecast is queued at the accepting edge.
    task automatic send_sample(input logic [31:0] sp, input logic [31:0] fb,
                               input bit known, input outcome_t given);
        outcome_t f;
        if (!steady && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < 7) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {fb, sp};
        do @(posedge aclk); while (!s_tready);
        f = predict_drive(sp, fb);
        drive_forecast.push_back(known ? given : f);
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (drive_forecast.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    function automatic void plan_write(input pcpd_pkg::cfg_index_t idx,
                                       input logic [31:0] val);
        plan_row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.a        = val;
        plan.push_back(r);
    endfunction

    function automatic void plan_sample(input logic [31:0] sp, input logic [31:0] fb,
                                        input bit known, input logic [31:0] drive,
                                        input logic skipped);
        plan_row_t r;
        r = '0;
        r.a              = sp;
        r.b              = fb;
        r.known          = known;
        r.result.drive   = drive;
        r.result.skipped = skipped;
        plan.push_back(r);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(5))
            0:       return '0;
            1:       return LIMIT_MAX;
            2, 3:    return GAIN_W'($urandom_range(32'h0003_0000));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_limit();
        case ($urandom_range(7))
            0:       return '0;
            1, 2:    return LIMIT_MAX;
            3, 4:    return GAIN_W'($urandom_range(32'h0010_0000));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    // Result side: random back-pressure and the comparison.
    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (drive_forecast.size() == 0) begin
                report_mismatch($sformatf("unexpected result drive=%h", m_tdata));
            end else begin
                want = drive_forecast.pop_front();
                if (m_tdata !== want.drive)
                    report_mismatch($sformatf("drive %h, expected %h", m_tdata, want.drive));
                if (m_tuser[0] !== want.skipped)
                    report_mismatch($sformatf("skipped %b, expected %b",
                                              m_tuser[0], want.skipped));
            end
        end
        m_tready <= steady || ($urandom_range(99) >= 7);
    end

    // Watchdog on cycles with no transaction on either stream.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        plan_row_t   row;
        logic [31:0] sp, fb;
        int          delta;
        outcome_t    none;

        none = '0;
        kp = '0; ki = '0; kd = '0;
        integ_lim = LIMIT_MAX; out_lim = LIMIT_MAX; err_ceiling = LIMIT_MAX;
        dead_band = '0;
        law = pcpd_pkg::MODE_POSITIONAL;
        err_z1 = '0; err_z2 = '0; integ_acc = '0; incr_hold = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults: zero gains, full limits.
        plan_sample(32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 1'b0);
        plan_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0, 1'b1);  // error beyond the signed 32-bit range
        plan_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0, 1'b1);
        plan_sample(32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'h0, 1'b0);  // error at the ceiling
        plan_sample(32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0, 1'b1);
        plan_sample(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0);
        // Moderate positional gains.
        plan_write(pcpd_pkg::CFG_GAIN_P, 32'h0001_0000);
        plan_write(pcpd_pkg::CFG_GAIN_I, 32'h0000_8000);
        plan_write(pcpd_pkg::CFG_GAIN_D, 32'h0000_4000);
        plan_sample(32'h0003_0000, 32'h0001_0000, 1'b0, 32'h0, 1'b0);
        plan_sample(32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 1'b0);
        plan_sample(32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0);
        // Largest gains against tight clamps.
        plan_write(pcpd_pkg::CFG_GAIN_P, 32'h7FFF_FFFF);
        plan_write(pcpd_pkg::CFG_GAIN_I, 32'h7FFF_FFFF);
        plan_write(pcpd_pkg::CFG_GAIN_D, 32'h7FFF_FFFF);
        plan_write(pcpd_pkg::CFG_INTEGRAL_CLAMP, 32'h0005_0000);
        plan_write(pcpd_pkg::CFG_OUTPUT_CLAMP, 32'h0010_0000);
        plan_sample(32'h0000_1000, 32'h0000_0000, 1'b0, 32'h0, 1'b0);
        plan_sample(32'hFFFF_F000, 32'h0000_2000, 1'b0, 32'h0, 1'b0);
        // An output clamp of zero forces the drive to zero.
        plan_write(pcpd_pkg::CFG_OUTPUT_CLAMP, 32'h0);
        plan_sample(32'h0001_2345, 32'h0000_0000, 1'b1, 32'h0, 1'b0);
        plan_write(pcpd_pkg::CFG_OUTPUT_CLAMP, 32'h7FFF_FFFF);
        plan_write(pcpd_pkg::CFG_INTEGRAL_CLAMP, 32'h0);
        plan_write(pcpd_pkg::CFG_GAIN_P, 32'h0002_0000);
        plan_write(pcpd_pkg::CFG_GAIN_D, 32'h0);
        plan_sample(32'h0004_0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0);
        // Dead zone and ceiling edges: equal values are processed.
        plan_write(pcpd_pkg::CFG_DEAD_ZONE, 32'h0001_0000);
        plan_write(pcpd_pkg::CFG_ERROR_CEILING, 32'h0010_0000);
        plan_sample(32'h0000_FFFF, 32'h0000_0000, 1'b1, 32'h0, 1'b1);
        plan_sample(32'h0001_0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0);
        plan_sample(32'h0000_0000, 32'hFFF0_0000, 1'b0, 32'h0, 1'b0);
        plan_sample(32'h0010_0001, 32'h0000_0000, 1'b1, 32'h0, 1'b1);
        plan_sample(32'hFFEF_FFFF, 32'h0000_0000, 1'b1, 32'h0, 1'b1);
        // Incremental law.
        plan_write(pcpd_pkg::CFG_LOOP_MODE, 32'(pcpd_pkg::MODE_INCREMENTAL));
        plan_write(pcpd_pkg::CFG_DEAD_ZONE, 32'h0);
        plan_write(pcpd_pkg::CFG_ERROR_CEILING, 32'h7FFF_FFFF);
        plan_write(pcpd_pkg::CFG_INTEGRAL_CLAMP, 32'h0003_0000);
        plan_write(pcpd_pkg::CFG_GAIN_P, 32'h0001_0000);
        plan_write(pcpd_pkg::CFG_GAIN_I, 32'h0000_4000);
        plan_write(pcpd_pkg::CFG_GAIN_D, 32'h0000_2000);
        plan_sample(32'h0002_0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0);
        plan_sample(32'h0005_0000, 32'h0001_0000, 1'b0, 32'h0, 1'b0);
        plan_sample(32'hFFFF_0000, 32'h0003_0000, 1'b0, 32'h0, 1'b0);
        plan_sample(32'h7FFF_FFFF, 32'h8000_0001, 1'b1, 32'h0, 1'b1);
        plan_sample(32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0, 1'b1);
        plan_write(pcpd_pkg::CFG_OUTPUT_CLAMP, 32'h0000_8000);
        plan_sample(32'h0020_0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0);
        plan_sample(32'hFFE0_0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0);

        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_write) begin
                drain_results();
                write_reg(row.reg_idx, row.a[GAIN_W-1:0]);
            end else begin
                send_sample(row.a, row.b, row.known, row.result);
            end
        end

        // Random phases, each with its own register settings.
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            if (ph == 6) begin
                // All gains and limits at their maximum.
                write_reg(pcpd_pkg::CFG_GAIN_P, LIMIT_MAX);
                write_reg(pcpd_pkg::CFG_GAIN_I, LIMIT_MAX);
                write_reg(pcpd_pkg::CFG_GAIN_D, LIMIT_MAX);
                write_reg(pcpd_pkg::CFG_INTEGRAL_CLAMP, LIMIT_MAX);
                write_reg(pcpd_pkg::CFG_OUTPUT_CLAMP, LIMIT_MAX);
                write_reg(pcpd_pkg::CFG_DEAD_ZONE, '0);
                write_reg(pcpd_pkg::CFG_ERROR_CEILING, LIMIT_MAX);
            end else begin
                write_reg(pcpd_pkg::CFG_GAIN_P, pick_gain());
                write_reg(pcpd_pkg::CFG_GAIN_I, pick_gain());
                write_reg(pcpd_pkg::CFG_GAIN_D, pick_gain());
                write_reg(pcpd_pkg::CFG_INTEGRAL_CLAMP, pick_limit());
                write_reg(pcpd_pkg::CFG_OUTPUT_CLAMP, pick_limit());
                // Keep most samples inside the window so the history evolves.
                write_reg(pcpd_pkg::CFG_DEAD_ZONE, ($urandom_range(3) == 0) ?
                          GAIN_W'(0) : GAIN_W'($urandom_range(32'h0000_8000)));
                write_reg(pcpd_pkg::CFG_ERROR_CEILING, ($urandom_range(2) == 0) ?
                          LIMIT_MAX : GAIN_W'($urandom_range(32'h7FFF_FFFF, 32'h0004_0000)));
            end
            write_reg(pcpd_pkg::CFG_LOOP_MODE,
                      ph[0] ? GAIN_W'(pcpd_pkg::MODE_INCREMENTAL)
                            : GAIN_W'(pcpd_pkg::MODE_POSITIONAL));
            steady <= (ph == 3);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == PHASE_ITEMS / 2) drain_results();
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        // Small error around a random operating point.
                        fb = $urandom;
                        delta = $urandom_range(32'h0006_0000) - 32'h0003_0000;
                        sp = fb + delta;
                    end
                    4, 5, 6: begin
                        sp = $signed($urandom) >>> $urandom_range(15, 1);
                        fb = $signed($urandom) >>> $urandom_range(15, 1);
                    end
                    default: begin
                        sp = $urandom;
                        fb = $urandom;
                    end
                endcase
                send_sample(sp, fb, 1'b0, none);
            end
        end
        steady <= 1'b0;
        drain_results();

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
